>>> hdl/gds_pkg.sv
// Shared widths, codes, the queued job record and calendar helper functions.
`timescale 1ns / 1ps
`default_nettype none

package gds_pkg;

    // Field widths of the request and response.
    localparam int AMOUNT_BITS = 12;
    localparam int KIND_W      = 2;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;

    // A week request becomes seven times as many day steps.
    localparam int STEP_W      = AMOUNT_BITS + 3;

    // Year limits and month numbers.
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_LONG  = DAY_W'(31);
    localparam logic [DAY_W-1:0]   DAY_SHORT = DAY_W'(30);
    localparam logic [DAY_W-1:0]   DAY_LEAP  = DAY_W'(29);
    localparam logic [DAY_W-1:0]   DAY_FEB   = DAY_W'(28);

    // Year remainder counters kept beside the year for the leap rule.
    localparam int R4_W   = 2;
    localparam int R100_W = 7;
    localparam int R400_W = 9;
    localparam logic [R4_W-1:0]   R4_TOP   = R4_W'(3);
    localparam logic [R100_W-1:0] R100_TOP = R100_W'(99);
    localparam logic [R400_W-1:0] R400_TOP = R400_W'(399);

    // Year / 400 through a reciprocal: floor(y * 5243 / 2^21) is exact below 16384.
    localparam int PROD_W      = 27;
    localparam int RECIP_400   = 5243;
    localparam int RECIP_SHIFT = 21;
    localparam int Q400_W      = 5;

    // Unit codes of a request.
    typedef enum logic [KIND_W-1:0] {
        KIND_DAYS   = 2'd0,
        KIND_WEEKS  = 2'd1,
        KIND_MONTHS = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Back end stepper states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

    // One classified request, ready for the stepper.
    typedef struct packed {
        logic                  months;
        logic [STEP_W-1:0]     steps;
        logic [DAY_W-1:0]      day;
        logic [MONTH_W-1:0]    month;
        logic [YEAR_W-1:0]     year;
        logic [R4_W-1:0]       r4;
        logic [R100_W-1:0]     r100;
        logic [R400_W-1:0]     r400;
    } t_job;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Leap rule from the year's remainders by 4, 100 and 400.
    function automatic logic f_leap(
        input logic [R4_W-1:0]   r4,
        input logic [R100_W-1:0] r100,
        input logic [R400_W-1:0] r400
    );
        f_leap = (r400 == '0) || ((r4 == '0) && (r100 != '0));
    endfunction

    // Length of a month; February follows the leap flag.
    function automatic logic [DAY_W-1:0] f_month_len(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        unique case (month) inside
            MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_SHORT;
            MONTH_FEB: len = leap ? DAY_LEAP : DAY_FEB;
            default:   len = DAY_LONG;
        endcase
        f_month_len = len;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gds_if.sv
// Request and response channel interfaces with valid/ready handshakes.
`timescale 1ns / 1ps
`default_nettype none

interface gds_in_if
    import gds_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [AMOUNT_BITS-1:0] amount;
    logic [DAY_W-1:0]       start_day;
    logic [MONTH_W-1:0]     start_month;
    logic [YEAR_W-1:0]      start_year;

    modport source (
        output valid, kind, amount, start_day, start_month, start_year,
        input  ready
    );
    modport sink (
        input  valid, kind, amount, start_day, start_month, start_year,
        output ready
    );
endinterface

interface gds_out_if
    import gds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               underflow;

    modport source (
        output valid, result_day, result_month, result_year, underflow,
        input  ready
    );
    modport sink (
        input  valid, result_day, result_month, result_year, underflow,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/gds_front.sv
// Front end: accepts a request, normalizes the date and classifies the unit into a job.
`timescale 1ns / 1ps
`default_nettype none

module gds_front
    import gds_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gds_in_if.sink     i_req,
    output t_job       o_job,
    output logic       o_job_vld,
    input  wire logic  i_job_rdy
);

    logic                   r_vld;
    logic                   r_months;
    logic [STEP_W-1:0]      r_steps;
    logic [DAY_W-1:0]       r_day;
    logic [MONTH_W-1:0]     r_month;
    logic [YEAR_W-1:0]      r_year;
    logic [Q400_W-1:0]      r_q400;

    logic                   accept;
    logic [MONTH_W-1:0]     month_n;
    logic [YEAR_W-1:0]      year_n;
    logic [DAY_W-1:0]       day_n;
    logic [STEP_W-1:0]      steps_n;
    logic [PROD_W-1:0]      prod;

    logic [YEAR_W-1:0]      q_times;
    logic [R400_W-1:0]      r400;
    logic [R100_W-1:0]      r100;
    logic                   leap;
    logic [DAY_W-1:0]       len;

    // The holding stage frees as soon as the queue takes its job.
    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_vld || i_job_rdy;

    // Clamp month and year into range, lift a zero day, and count the steps.
    always_comb begin
        month_n = i_req.start_month;
        if (i_req.start_month < MONTH_JAN) begin
            month_n = MONTH_JAN;
        end else if (i_req.start_month > MONTH_DEC) begin
            month_n = MONTH_DEC;
        end
        year_n = i_req.start_year;
        if (i_req.start_year < YEAR_MIN) begin
            year_n = YEAR_MIN;
        end else if (i_req.start_year > YEAR_MAX) begin
            year_n = YEAR_MAX;
        end
        day_n = (i_req.start_day < DAY_FIRST) ? DAY_FIRST : i_req.start_day;
        unique case (t_kind'(i_req.kind))
            KIND_DAYS:   steps_n = STEP_W'(i_req.amount);
            KIND_WEEKS:  steps_n = (STEP_W'(i_req.amount) << 3) - STEP_W'(i_req.amount);
            KIND_MONTHS: steps_n = STEP_W'(i_req.amount);
            default:     steps_n = '0;
        endcase
        prod = PROD_W'(year_n) * PROD_W'(RECIP_400);
    end

    // Holding stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_job_rdy) begin
            r_vld <= 1'b0;
        end
    end

    // Holding stage payload, with the year quotient by 400 already formed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_months <= (t_kind'(i_req.kind) == KIND_MONTHS);
            r_steps  <= steps_n;
            r_day    <= day_n;
            r_month  <= month_n;
            r_year   <= year_n;
            r_q400   <= prod[RECIP_SHIFT +: Q400_W];
        end
    end

    // Remainders of the year, the leap flag and the upper day clamp.
    always_comb begin
        q_times = YEAR_W'(r_q400) * YEAR_W'(400);
        r400    = R400_W'(r_year - q_times);
        if (r400 >= R400_W'(300)) begin
            r100 = R100_W'(r400 - R400_W'(300));
        end else if (r400 >= R400_W'(200)) begin
            r100 = R100_W'(r400 - R400_W'(200));
        end else if (r400 >= R400_W'(100)) begin
            r100 = R100_W'(r400 - R400_W'(100));
        end else begin
            r100 = R100_W'(r400);
        end
        leap = f_leap(r_year[R4_W-1:0], r100, r400);
        len  = f_month_len(r_month, leap);

        o_job.months = r_months;
        o_job.steps  = r_steps;
        o_job.day    = (r_day > len) ? len : r_day;
        o_job.month  = r_month;
        o_job.year   = r_year;
        o_job.r4     = r_year[R4_W-1:0];
        o_job.r100   = r100;
        o_job.r400   = r400;
    end

    assign o_job_vld = r_vld;

endmodule

`default_nettype wire

>>> hdl/gds_queue.sv
// Two-entry job queue between the front end and the stepper.
`timescale 1ns / 1ps
`default_nettype none

module gds_queue
    import gds_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_vld,
    output logic       o_push_rdy,
    input  wire t_job  i_push_job,
    output logic       o_pop_vld,
    input  wire logic  i_pop_rdy,
    output t_job       o_pop_job
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic push;
    logic pop;

    assign o_push_rdy = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;
    assign o_pop_job  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gds_back.sv
// Back end: steps the date back one day or one month per cycle and holds the response.
`timescale 1ns / 1ps
`default_nettype none

module gds_back
    import gds_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_job_vld,
    output logic       o_job_rdy,
    input  wire t_job  i_job,
    gds_out_if.source  o_rsp
);

    t_back_state         r_state;
    t_back_state         n_state;

    logic                r_months;
    logic [STEP_W-1:0]   r_left;
    logic [DAY_W-1:0]    r_day;
    logic [MONTH_W-1:0]  r_month;
    logic [YEAR_W-1:0]   r_year;
    logic [R4_W-1:0]     r_r4;
    logic [R100_W-1:0]   r_r100;
    logic [R400_W-1:0]   r_r400;
    logic                r_uflow;

    logic [DAY_W-1:0]    n_day;
    logic [MONTH_W-1:0]  n_month;
    logic [YEAR_W-1:0]   n_year;
    logic [R4_W-1:0]     n_r4;
    logic [R100_W-1:0]   n_r100;
    logic [R400_W-1:0]   n_r400;
    logic                n_uflow;

    logic                r_o_vld;
    logic [DAY_W-1:0]    r_o_day;
    logic [MONTH_W-1:0]  r_o_month;
    logic [YEAR_W-1:0]   r_o_year;
    logic                r_o_uflow;

    logic                out_free;
    logic                done;
    logic                load;
    logic                step;
    logic                finish;

    logic                leap;
    logic [MONTH_W-1:0]  month_prev;
    logic [DAY_W-1:0]    len_prev;

    assign out_free = !r_o_vld || o_rsp.ready;
    assign done     = (r_left == '0) || r_uflow;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_vld) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        load   = 1'b0;
        step   = 1'b0;
        finish = 1'b0;
        unique case (r_state)
            ST_IDLE: load = i_job_vld;
            ST_RUN: begin
                step   = !done;
                finish = done && out_free;
            end
            default: ;
        endcase
    end

    assign o_job_rdy = load;

    // One step back: a day or a month, with year wrap and underflow to 1/1/1.
    always_comb begin
        leap       = f_leap(r_r4, r_r100, r_r400);
        month_prev = r_month - 1'b1;
        len_prev   = f_month_len(month_prev, leap);

        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_r4    = r_r4;
        n_r100  = r_r100;
        n_r400  = r_r400;
        n_uflow = r_uflow;

        if (!r_months && (r_day > DAY_FIRST)) begin
            n_day = r_day - 1'b1;
        end else if (r_month > MONTH_JAN) begin
            n_month = month_prev;
            if (!r_months || (r_day > len_prev)) begin
                n_day = len_prev;
            end
        end else if (r_year > YEAR_MIN) begin
            n_year  = r_year - 1'b1;
            n_month = MONTH_DEC;
            if (!r_months) begin
                n_day = DAY_LONG;
            end
            n_r4   = (r_r4 == '0) ? R4_TOP : r_r4 - 1'b1;
            n_r100 = (r_r100 == '0) ? R100_TOP : r_r100 - 1'b1;
            n_r400 = (r_r400 == '0) ? R400_TOP : r_r400 - 1'b1;
        end else begin
            n_day   = DAY_FIRST;
            n_month = MONTH_JAN;
            n_year  = YEAR_MIN;
            n_uflow = 1'b1;
        end
    end

    // State and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Working date and step count.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_months <= i_job.months;
            r_left   <= i_job.steps;
            r_day    <= i_job.day;
            r_month  <= i_job.month;
            r_year   <= i_job.year;
            r_r4     <= i_job.r4;
            r_r100   <= i_job.r100;
            r_r400   <= i_job.r400;
            r_uflow  <= 1'b0;
        end else if (step) begin
            r_left   <= r_left - 1'b1;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
            r_r4     <= n_r4;
            r_r100   <= n_r100;
            r_r400   <= n_r400;
            r_uflow  <= n_uflow;
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_day   <= r_day;
            r_o_month <= r_month;
            r_o_year  <= r_year;
            r_o_uflow <= r_uflow;
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.result_day   = r_o_day;
    assign o_rsp.result_month = r_o_month;
    assign o_rsp.result_year  = r_o_year;
    assign o_rsp.underflow    = r_o_uflow;

endmodule

`default_nettype wire

>>> hdl/gregorian_date_subtractor_top.sv
// Top level of the date subtractor: front end, job queue and stepper.
//
//   Channel   Direction   Handshake        Carries
//   i_req     in          valid / ready    kind, amount, start date
//   o_rsp     out         valid / ready    result date, underflow
//
// A request passes through the front end's holding register and a queue entry; the
// stepper then loads it and steps back one day (amount, or amount * 7 for weeks) or one
// month per cycle before it finishes; the single-step stepper sets the rate.
// An underflow ends the stepping at once. Reset is synchronous and active low;
// it empties the queue and the stepper. Either side may stall: the queue and the
// response register let the front keep accepting while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_subtractor_top
    import gds_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gds_in_if.sink     i_req,
    gds_out_if.source  o_rsp
);

    t_job  front_job;
    logic  front_vld;
    logic  front_rdy;
    t_job  queue_job;
    logic  queue_vld;
    logic  queue_rdy;

    gds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_job     (front_job),
        .o_job_vld (front_vld),
        .i_job_rdy (front_rdy)
    );

    gds_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .o_push_rdy (front_rdy),
        .i_push_job (front_job),
        .o_pop_vld  (queue_vld),
        .i_pop_rdy  (queue_rdy),
        .o_pop_job  (queue_job)
    );

    gds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (queue_vld),
        .o_job_rdy (queue_rdy),
        .i_job     (queue_job),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

>>> hdl/gds_checker.sv
// Port-level checks on the date subtractor, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module gds_checker
    import gds_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [DAY_W-1:0]   i_day,
    input wire logic [MONTH_W-1:0] i_month,
    input wire logic [YEAR_W-1:0]  i_year,
    input wire logic               i_underflow
);

    // No response is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid right after reset");

    // A stalled response stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response withdrawn while stalled");

    // A stalled response keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_day) && $stable(i_month) && $stable(i_year) && $stable(i_underflow))
        else $error("response payload changed while stalled");

    // An underflow always reports the first day of year one.
    a_uflow_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_underflow |->
            (i_day == DAY_FIRST) && (i_month == MONTH_JAN) && (i_year == YEAR_MIN))
        else $error("underflow without 1/1/1");

    // Every result is a date in range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_day >= DAY_FIRST) && (i_day <= DAY_LONG) &&
            (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC) &&
            (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX))
        else $error("result date out of range");

endmodule

bind gregorian_date_subtractor_top gds_checker u_gds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_day       (o_rsp.result_day),
    .i_month     (o_rsp.result_month),
    .i_year      (o_rsp.result_year),
    .i_underflow (o_rsp.underflow)
);

`default_nettype wire
